// ----- rtl/core/jdg_pkg.sv -----
package jdg_pkg;

  // Pipeline depth: input register, five working stages, result register.
  localparam int unsigned PIPE_DEPTH = 7;

  // Valid Gregorian window of Julian day numbers.
  localparam logic [22:0] JDN_FIRST = 23'd2299161;   // 1582-10-15
  localparam logic [22:0] JDN_LAST  = 23'd5373484;   // 9999-12-31

  // Century term: alpha = floor((4z - 7468865) / 146097), numerator below 2^24.
  localparam logic [24:0] ALPHA_OFFSET = 25'd7468865;
  localparam int unsigned ALPHA_SHIFT  = 42;
  localparam logic [24:0] ALPHA_RECIP  = 25'((64'd1 << ALPHA_SHIFT) / 64'd146097 + 64'd1);

  // b = z + 1 + alpha - alpha/4 + 1524
  localparam logic [22:0] B_OFFSET = 23'd1525;

  // Year term: c = floor((20b - 2442) / 7305), numerator below 2^27.
  localparam logic [26:0] C_OFFSET = 27'd2442;
  localparam int unsigned C_SHIFT  = 40;
  localparam logic [27:0] C_RECIP  = 28'((64'd1 << C_SHIFT) / 64'd7305 + 64'd1);

  // d = floor(1461 c / 4)
  localparam logic [10:0] D_MULT = 11'd1461;

  // Month term: e = floor(10000 y / 306001), y below 512.
  localparam int unsigned E_SHIFT = 30;
  localparam logic [25:0] E_RECIP = 26'((64'd10000 << E_SHIFT) / 64'd306001 + 64'd1);

  localparam logic [13:0] YEAR_OFS_LATE  = 14'd4716;
  localparam logic [13:0] YEAR_OFS_EARLY = 14'd4715;

  // Handshake control shared between the flow controller and the datapath.
  typedef struct packed {
    logic [PIPE_DEPTH-1:0] en;   // stage loads this cycle
    logic [PIPE_DEPTH-1:0] vld;  // stage holds a word
  } flow_t;

  // floor(30.6001 * e) for e in 0..15.
  function automatic logic [8:0] month_days(input logic [3:0] e);
    logic [8:0] r;
    unique case (e)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/jdg_flow.sv -----
module jdg_flow (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_ready,
  output jdg_pkg::flow_t flow
);
  import jdg_pkg::*;

  logic [PIPE_DEPTH-1:0] en;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;

  // A stage loads when it is empty or its successor loads (bubbles collapse).
  assign en[PIPE_DEPTH-1] = !vld_r[PIPE_DEPTH-1] || out_ready;

  for (genvar k = 0; k < PIPE_DEPTH - 1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int unsigned k = 1; k < PIPE_DEPTH; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign flow.en  = en;
  assign flow.vld = vld_r;

endmodule

// ----- rtl/core/julian_day_to_gregorian_date.sv -----
// Channel | Dir | tdata fields (low bit up)                | tuser
// in_     | in  | day_number[22:0], pad[23]                | -
// out_    | out | day_of_month[4:0], month_of_year[8:5],   | range_error
//         |     | year_value[22:9], pad[23]                |
//
// Seven-stage pipeline, one word accepted per cycle unless out_tready stalls the
// output. The multiplier stages (reciprocal divides by 146097, 7305 and
// 306001/10000, and the 1461 product) set depth.
// rst_n (synchronous) empties every stage; payload registers are not reset.
// A stall on out_tready backs up stage by stage; in_tready drops only when
// every stage holds a word.
module julian_day_to_gregorian_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [22:0] day_number, [23] zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [4:0] day_of_month, [8:5] month_of_year,
                                  // [22:9] year_value, [23] zero pad
  output logic        out_tuser   // [0] range_error
);
  import jdg_pkg::*;

  flow_t flow;

  jdg_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .flow      (flow)
  );

  assign in_tready = flow.en[0];

  // ---------------- stage 1: input register ----------------
  logic [22:0] s1_z_r;

  always_ff @(posedge clk) begin
    if (flow.en[0]) begin
      s1_z_r <= in_tdata[22:0];
    end
  end

  // ---------------- stage 2: range check, alpha product ----------------
  logic        s2_err_nxt;
  logic [23:0] s2_num;
  logic [48:0] s2_prod_nxt;
  logic [22:0] s2_z_r;
  logic        s2_err_r;
  logic [48:0] s2_prod_r;

  always_comb begin
    s2_err_nxt  = (s1_z_r < JDN_FIRST) || (s1_z_r > JDN_LAST);
    // 4z - 7468865; wraps only for out-of-range input, which is masked
    s2_num      = 24'({s1_z_r, 2'b00} - ALPHA_OFFSET);
    s2_prod_nxt = 49'(s2_num) * 49'(ALPHA_RECIP);
  end

  always_ff @(posedge clk) begin
    if (flow.en[1]) begin
      s2_z_r    <= s1_z_r;
      s2_err_r  <= s2_err_nxt;
      s2_prod_r <= s2_prod_nxt;
    end
  end

  // ---------------- stage 3: b = z + 1 + alpha - alpha/4 + 1524 ----------------
  logic [6:0]  s3_alpha;
  logic [22:0] s3_b_nxt;
  logic [22:0] s3_b_r;
  logic        s3_err_r;

  always_comb begin
    s3_alpha = s2_prod_r[ALPHA_SHIFT +: 7];
    s3_b_nxt = s2_z_r + 23'(s3_alpha) - 23'(s3_alpha >> 2) + B_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (flow.en[2]) begin
      s3_b_r   <= s3_b_nxt;
      s3_err_r <= s2_err_r;
    end
  end

  // ---------------- stage 4: c product ----------------
  logic [26:0] s4_num;
  logic [54:0] s4_prod_nxt;
  logic [54:0] s4_prod_r;
  logic [22:0] s4_b_r;
  logic        s4_err_r;

  always_comb begin
    // 20b - 2442 as (16b + 4b) - 2442
    s4_num      = 27'({s3_b_r, 4'b0000}) + 27'({s3_b_r, 2'b00}) - C_OFFSET;
    s4_prod_nxt = 55'(s4_num) * 55'(C_RECIP);
  end

  always_ff @(posedge clk) begin
    if (flow.en[3]) begin
      s4_prod_r <= s4_prod_nxt;
      s4_b_r    <= s3_b_r;
      s4_err_r  <= s3_err_r;
    end
  end

  // ---------------- stage 5: c, y = b - floor(1461c/4) ----------------
  logic [14:0] s5_c_nxt;
  logic [25:0] s5_d_prod;
  logic [8:0]  s5_y_nxt;
  logic [14:0] s5_c_r;
  logic [8:0]  s5_y_r;
  logic        s5_err_r;

  always_comb begin
    s5_c_nxt  = s4_prod_r[C_SHIFT +: 15];
    s5_d_prod = 26'(s5_c_nxt) * 26'(D_MULT);
    // b - d stays below 490 in range
    s5_y_nxt  = 9'(s4_b_r - s5_d_prod[24:2]);
  end

  always_ff @(posedge clk) begin
    if (flow.en[4]) begin
      s5_c_r   <= s5_c_nxt;
      s5_y_r   <= s5_y_nxt;
      s5_err_r <= s4_err_r;
    end
  end

  // ---------------- stage 6: e product ----------------
  logic [34:0] s6_prod_nxt;
  logic [34:0] s6_prod_r;
  logic [14:0] s6_c_r;
  logic [8:0]  s6_y_r;
  logic        s6_err_r;

  assign s6_prod_nxt = 35'(s5_y_r) * 35'(E_RECIP);

  always_ff @(posedge clk) begin
    if (flow.en[5]) begin
      s6_prod_r <= s6_prod_nxt;
      s6_c_r    <= s5_c_r;
      s6_y_r    <= s5_y_r;
      s6_err_r  <= s5_err_r;
    end
  end

  // ---------------- stage 7: day, month, year; result register ----------------
  logic [3:0]  s7_e;
  logic [3:0]  s7_month;
  logic [4:0]  out_day_nxt;
  logic [3:0]  out_month_nxt;
  logic [13:0] out_year_nxt;
  logic [4:0]  out_day_r;
  logic [3:0]  out_month_r;
  logic [13:0] out_year_r;
  logic        out_err_r;

  always_comb begin
    s7_e     = s6_prod_r[E_SHIFT +: 4];
    // E up to 13 -> E-1 (Mar..Dec), 14 and 15 -> Jan, Feb
    s7_month = (s7_e <= 4'd13) ? 4'(s7_e - 4'd1) : 4'(s7_e - 4'd13);
    if (s6_err_r) begin
      out_day_nxt   = '0;
      out_month_nxt = '0;
      out_year_nxt  = '0;
    end else begin
      out_day_nxt   = 5'(s6_y_r - month_days(s7_e));
      out_month_nxt = s7_month;
      out_year_nxt  = (s7_month > 4'd2) ? 14'(s6_c_r - 15'(YEAR_OFS_LATE))
                                        : 14'(s6_c_r - 15'(YEAR_OFS_EARLY));
    end
  end

  always_ff @(posedge clk) begin
    if (flow.en[6]) begin
      out_day_r   <= out_day_nxt;
      out_month_r <= out_month_nxt;
      out_year_r  <= out_year_nxt;
      out_err_r   <= s6_err_r;
    end
  end

  assign out_tvalid = flow.vld[PIPE_DEPTH-1];
  assign out_tdata  = {1'b0, out_year_r, out_month_r, out_day_r};
  assign out_tuser  = out_err_r;

endmodule

// ----- rtl/core/jdg_checker.sv -----
module jdg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // held result must not change under backpressure
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // empty result stage means the whole pipe can take a word
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // out-of-range words carry an all-zero date
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 24'd0)
    else $error("range error with nonzero date");

  // in-range words carry a legal date
  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[4:0] != 5'd0 && out_tdata[8:5] != 4'd0 && out_tdata[8:5] <= 4'd12 &&
      out_tdata[22:9] >= 14'd1582 && out_tdata[22:9] <= 14'd9999 && !out_tdata[23])
    else $error("illegal date on output");

endmodule

bind julian_day_to_gregorian_date jdg_checker u_jdg_checker (.*);
